@@ hw/rtl/eepf_pkg.sv @@
// ----------------------------------------------------------------------------
// eepf_pkg: shared types, constants and tables for the EEPROM page framer
// Part size tables, frame item layout and small helper functions.
// ----------------------------------------------------------------------------
package eepf_pkg;

    // memory address width, addresses wrap at 2^ADDR_WIDTH
    localparam int ADDR_WIDTH = 16;
    localparam logic [15:0] ADDR_MASK = 16'((17'd1 << ADDR_WIDTH) - 17'd1);
    localparam logic [16:0] ADDR_SPAN = 17'(17'd1 << ADDR_WIDTH);

    // most result items one input item can cause
    localparam int NOUT  = 5;
    localparam int CNT_W = $clog2(NOUT + 1);
    localparam int IDX_W = $clog2(NOUT);

    // largest valid part size index
    localparam logic [3:0] TYPE_MAX = 4'd9;
    // first part size index with two address bytes
    localparam logic [3:0] TYPE_TWO_BYTE = 4'd5;

    // configuration register indexes
    localparam logic REG_DEVICE_TYPE = 1'b0;
    localparam logic REG_BUS_ADDRESS = 1'b1;

    localparam logic [6:0] BUS_ADDRESS_RESET = 7'd80;

    typedef enum logic [2:0] {
        KIND_START_WRITE = 3'd0,
        KIND_START_READ  = 3'd1,
        KIND_PAYLOAD     = 3'd2,
        KIND_STOP_WAIT   = 3'd3,
        KIND_STOP        = 3'd4,
        KIND_STATUS      = 3'd5
    } frame_kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_STRAY = 2'd2
    } status_t;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    typedef struct packed {
        frame_kind_t kind;
        logic [7:0]  frame_byte;
        logic [15:0] read_count;
        status_t     status;
        logic        last;
    } frame_item_t;

    // all results of one input item
    typedef struct packed {
        frame_item_t [NOUT-1:0] items;
    } frame_list_t;

    typedef struct packed {
        logic [3:0] device_type;
        logic [6:0] bus_address;
    } eepf_cfg_t;

    // clamp unknown part size codes to the largest part
    function automatic logic [3:0] type_index(input logic [3:0] dt);
        return (dt > TYPE_MAX) ? TYPE_MAX : dt;
    endfunction

    // capacity in bytes, limited by the address width
    function automatic logic [16:0] capacity(input logic [3:0] t);
        logic [16:0] c;
        c = 17'(17'd128 << t);
        return (c > ADDR_SPAN) ? ADDR_SPAN : c;
    endfunction

    // page size minus one
    function automatic logic [6:0] page_mask(input logic [3:0] t);
        logic [6:0] m;
        unique case (t)
            4'd0, 4'd1:       m = 7'd7;
            4'd2, 4'd3, 4'd4: m = 7'd15;
            4'd5, 4'd6:       m = 7'd31;
            4'd7, 4'd8:       m = 7'd63;
            default:          m = 7'd127;
        endcase
        return m;
    endfunction

    // device address with upper memory address bits folded in on small parts
    function automatic logic [7:0] dev_sel(input logic [3:0] t, input logic [6:0] b,
                                           input logic [15:0] a);
        logic [7:0] d;
        unique case (t)
            4'd2:    d = {1'b0, b[6:1], a[8]};
            4'd3:    d = {1'b0, b[6:2], a[9:8]};
            4'd4:    d = {1'b0, b[6:3], a[10:8]};
            default: d = {1'b0, b};
        endcase
        return d;
    endfunction

    function automatic frame_item_t mk_item(input frame_kind_t k, input logic [7:0] fb,
                                            input logic [15:0] rc, input status_t st);
        frame_item_t it;
        it.kind       = k;
        it.frame_byte = fb;
        it.read_count = rc;
        it.status     = st;
        it.last       = 1'b0;
        return it;
    endfunction

endpackage

@@ hw/rtl/i2c_eeprom_page_framer.sv @@
// ----------------------------------------------------------------------------
// i2c_eeprom_page_framer: serial EEPROM request to I2C transaction framer
// Top level with configuration registers, framer and output serialiser.
// ----------------------------------------------------------------------------
// Each accepted input item is framed into a list of one to five result items,
// which are then sent one item per cycle while m_tready is high. An item causes
// one or two results for a data byte inside a page, up to five at a page or
// request start and for a read request. The output serialiser sets the rate;
// the next input item is framed while the previous list is still draining, so
// there is no extra gap between lists. Write device_type and bus_address only
// while no request is in flight.
module i2c_eeprom_page_framer import eepf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_wdata,
    // request items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // start_address, length, data_byte
    input  logic [1:0]  s_tuser,   // operation, first
    // transaction items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // frame_byte, read_count, status, zero pad
    output logic [2:0]  m_tuser,   // frame_kind
    output logic        m_tlast
);

    eepf_cfg_t   cfg_reg;
    logic        list_valid;
    logic        list_ready;
    frame_list_t list;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_type <= 4'd0;
            cfg_reg.bus_address <= BUS_ADDRESS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_DEVICE_TYPE: cfg_reg.device_type <= cfg_wdata[3:0];
                REG_BUS_ADDRESS: cfg_reg.bus_address <= cfg_wdata;
                default: ;
            endcase
        end
    end

    eepf_framer u_framer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .list_valid (list_valid),
        .list_ready (list_ready),
        .list       (list)
    );

    eepf_emitter u_emitter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .list_valid (list_valid),
        .list_ready (list_ready),
        .list       (list),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

@@ hw/rtl/eepf_framer.sv @@
// ----------------------------------------------------------------------------
// eepf_framer: input register, request state and frame list builder
// Builds the full list of result items for the registered input item in one
// pass and hands it to the emitter, updating the request state as it goes.
// ----------------------------------------------------------------------------
module eepf_framer import eepf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  eepf_cfg_t   cfg,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [1:0]  s_tuser,
    output logic        list_valid,
    input  logic        list_ready,
    output frame_list_t list
);

    // input register
    logic        in_valid_reg, in_valid_next;
    op_t         op_reg;
    logic        first_reg;
    logic [15:0] sa_reg;
    logic [15:0] len_reg;
    logic [7:0]  db_reg;

    // request state
    logic        in_request_reg, in_request_next;
    logic        rejecting_reg, rejecting_next;
    logic [15:0] cur_addr_reg, cur_addr_next;
    logic [15:0] remaining_reg, remaining_next;

    logic        fire;
    logic [3:0]  t;
    logic [6:0]  pm;
    logic        two_byte;
    logic [15:0] sa_m;
    logic        over_range;

    logic        wr_go, wr_open;
    logic [15:0] wr_addr, wr_rem, wr_addr_inc, wr_rem_dec;
    frame_list_t list_c;
    logic [CNT_W-1:0] n;

    assign fire       = in_valid_reg && list_ready;
    assign s_tready   = !in_valid_reg || list_ready;
    assign list_valid = in_valid_reg;
    assign list       = list_c;

    assign t          = type_index(cfg.device_type);
    assign pm         = page_mask(t);
    assign two_byte   = (t >= TYPE_TWO_BYTE);
    assign sa_m       = sa_reg & ADDR_MASK;
    assign over_range = ({1'b0, sa_m} + {1'b0, len_reg}) > capacity(t);

    // write path: one data byte with page framing around it
    assign wr_addr     = (first_reg) ? sa_m : cur_addr_reg;
    assign wr_rem      = (first_reg) ? len_reg : remaining_reg;
    assign wr_open     = first_reg || ((wr_addr[6:0] & pm) == 7'd0);
    assign wr_addr_inc = (wr_addr + 16'd1) & ADDR_MASK;
    assign wr_rem_dec  = wr_rem - 16'd1;

    // build the item list and next state
    always_comb begin
        list_c          = '0;
        n               = '0;
        wr_go           = 1'b0;
        in_request_next = in_request_reg;
        rejecting_next  = rejecting_reg;
        cur_addr_next   = cur_addr_reg;
        remaining_next  = remaining_reg;

        if (op_reg == OP_READ || first_reg) begin
            in_request_next = 1'b0;
            rejecting_next  = 1'b0;
            remaining_next  = '0;
        end

        priority if (op_reg == OP_READ) begin
            if (len_reg == 16'd0) begin
                list_c.items[n] = mk_item(KIND_STATUS, 8'd0, 16'd0, ST_OK);
                n = n + 1'b1;
            end else if (over_range) begin
                list_c.items[n] = mk_item(KIND_STATUS, 8'd0, 16'd0, ST_RANGE);
                n = n + 1'b1;
            end else begin
                list_c.items[n] = mk_item(KIND_START_WRITE, dev_sel(t, cfg.bus_address, sa_m),
                                          16'd0, ST_OK);
                n = n + 1'b1;
                if (two_byte) begin
                    list_c.items[n] = mk_item(KIND_PAYLOAD, sa_m[15:8], 16'd0, ST_OK);
                    n = n + 1'b1;
                end
                list_c.items[n] = mk_item(KIND_PAYLOAD, sa_m[7:0], 16'd0, ST_OK);
                n = n + 1'b1;
                list_c.items[n] = mk_item(KIND_START_READ, dev_sel(t, cfg.bus_address, sa_m),
                                          len_reg, ST_OK);
                n = n + 1'b1;
                list_c.items[n] = mk_item(KIND_STOP, 8'd0, 16'd0, ST_OK);
                n = n + 1'b1;
            end
        end else if (first_reg) begin
            if (len_reg == 16'd0) begin
                list_c.items[n] = mk_item(KIND_STATUS, 8'd0, 16'd0, ST_OK);
                n = n + 1'b1;
            end else if (over_range) begin
                remaining_next  = len_reg - 16'd1;
                rejecting_next  = (len_reg != 16'd1);
                list_c.items[n] = mk_item(KIND_STATUS, 8'd0, 16'd0, ST_RANGE);
                n = n + 1'b1;
            end else begin
                wr_go = 1'b1;
            end
        end else if (in_request_reg) begin
            wr_go = 1'b1;
        end else if (rejecting_reg) begin
            remaining_next  = remaining_reg - 16'd1;
            rejecting_next  = (remaining_reg != 16'd1);
            list_c.items[n] = mk_item(KIND_STATUS, 8'd0, 16'd0, ST_RANGE);
            n = n + 1'b1;
        end else begin
            list_c.items[n] = mk_item(KIND_STATUS, 8'd0, 16'd0, ST_STRAY);
            n = n + 1'b1;
        end

        // data byte, with address phase at a request or page start and stop-wait at its end
        if (wr_go) begin
            if (wr_open) begin
                list_c.items[n] = mk_item(KIND_START_WRITE,
                                          dev_sel(t, cfg.bus_address, wr_addr), 16'd0, ST_OK);
                n = n + 1'b1;
                if (two_byte) begin
                    list_c.items[n] = mk_item(KIND_PAYLOAD, wr_addr[15:8], 16'd0, ST_OK);
                    n = n + 1'b1;
                end
                list_c.items[n] = mk_item(KIND_PAYLOAD, wr_addr[7:0], 16'd0, ST_OK);
                n = n + 1'b1;
            end
            list_c.items[n] = mk_item(KIND_PAYLOAD, db_reg, 16'd0, ST_OK);
            n = n + 1'b1;
            if (wr_rem_dec == 16'd0 || (wr_addr_inc[6:0] & pm) == 7'd0) begin
                list_c.items[n] = mk_item(KIND_STOP_WAIT, 8'd0, 16'd0, ST_OK);
                n = n + 1'b1;
            end
            cur_addr_next   = wr_addr_inc;
            remaining_next  = wr_rem_dec;
            in_request_next = (wr_rem_dec != 16'd0);
        end

        // mark the final item of the list
        for (int i = 0; i < NOUT; i++) begin
            if (CNT_W'(i + 1) == n) begin
                list_c.items[i].last = 1'b1;
            end
        end
    end

    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            in_request_reg <= 1'b0;
            rejecting_reg  <= 1'b0;
            cur_addr_reg   <= '0;
            remaining_reg  <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (fire) begin
                in_request_reg <= in_request_next;
                rejecting_reg  <= rejecting_next;
                cur_addr_reg   <= cur_addr_next;
                remaining_reg  <= remaining_next;
            end
        end
    end

    // input payload register
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg    <= op_t'(s_tuser[0]);
            first_reg <= s_tuser[1];
            sa_reg    <= s_tdata[15:0];
            len_reg   <= s_tdata[31:16];
            db_reg    <= s_tdata[39:32];
        end
    end

endmodule

@@ hw/rtl/eepf_emitter.sv @@
// ----------------------------------------------------------------------------
// eepf_emitter: result register and serialiser
// Holds one result list and presents one item per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module eepf_emitter import eepf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        list_valid,
    output logic        list_ready,
    input  frame_list_t list,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    frame_item_t [NOUT-1:0] items_reg;
    logic                   valid_reg, valid_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    frame_item_t            cur;
    logic                   load;

    assign cur        = items_reg[idx_reg];
    assign list_ready = !valid_reg || (m_tready && cur.last);
    assign load       = list_valid && list_ready;

    assign m_tvalid = valid_reg;
    assign m_tuser  = cur.kind;
    assign m_tlast  = cur.last;
    assign m_tdata  = {6'd0, cur.status, cur.read_count, cur.frame_byte};

    // step through the held list
    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = '0;
        end else if (valid_reg && m_tready) begin
            if (cur.last) begin
                valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (load) begin
            items_reg <= list.items;
        end
    end

endmodule
